// ===== design/lsba_pkg.sv =====
// Shared types and constants for the light sensor brightness averager.
package lsba_pkg;

  // Field widths of the channels and the configuration port
  localparam int unsigned AdcInW   = 12;
  localparam int unsigned PctW     = 7;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned CfgW     = 8;
  localparam int unsigned CfgIdxW  = 3;

  // Serial divider: quotient bits produced one per cycle while it is stepped
  localparam int unsigned QuoBits  = 8;
  localparam int unsigned StepW    = $clog2(QuoBits);

  // Scaling spans and gain format
  localparam int unsigned PctSpan  = 100;
  localparam int unsigned LvlSpan  = 250;
  localparam int unsigned GainFrac = 6;
  localparam int unsigned ProdW    = 2 * LevelW;
  localparam int unsigned GainedW  = ProdW - GainFrac;

  // Register reset values
  localparam logic [CfgW-1:0] MaxLevelRst  = 8'd100;
  localparam logic [CfgW-1:0] MinLevelRst  = 8'd15;
  localparam logic [CfgW-1:0] UpperSnapRst = 8'd140;
  localparam logic [CfgW-1:0] LowerSnapRst = 8'd40;
  localparam logic [CfgW-1:0] GainRst      = 8'd64;
  localparam logic [CfgW-1:0] ThreshRst    = 8'd5;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_LEVEL        = 3'd0,
    CFG_MIN_LEVEL        = 3'd1,
    CFG_UPPER_SNAP_LIMIT = 3'd2,
    CFG_LOWER_SNAP_LIMIT = 3'd3,
    CFG_GAIN_Q2_6        = 3'd4,
    CFG_CHANGE_THRESHOLD = 3'd5
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACC,
    ST_MEAN,
    ST_GAIN,
    ST_LEVEL,
    ST_DONE
  } state_e;

  // Control of one serial divider
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

// ===== design/lsba_in_if.sv =====
// Input channel: one converter sample per item.
interface lsba_in_if;
  logic                            valid;
  logic                            ready;
  logic [lsba_pkg::AdcInW-1:0]     adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

// ===== design/lsba_out_if.sv =====
// Output channel: percent, level and update flag per item.
interface lsba_out_if;
  logic                            valid;
  logic                            ready;
  logic [lsba_pkg::PctW-1:0]       raw_percent;
  logic [lsba_pkg::LevelW-1:0]     level;
  logic                            level_updated;

  modport source (output valid, output raw_percent, output level, output level_updated,
                  input ready);
  modport sink   (input valid, input raw_percent, input level, input level_updated,
                  output ready);
endinterface

// ===== design/lsba_serdiv.sv =====
// Restoring divider that yields one quotient bit per cycle while step is asserted.
module lsba_serdiv #(
  parameter int unsigned W = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lsba_pkg::div_ctrl_t            ctrl_i,
  input  logic [W-1:0]                   num_i,
  input  logic [W-1:0]                   den_i,
  output logic [lsba_pkg::QuoBits-1:0]   quo_o
);

  logic [W-1:0]                 rem_q;
  logic [W-1:0]                 den_q;
  logic [lsba_pkg::QuoBits-1:0] quo_q;
  logic                         fits;

  // Trial subtract of the aligned divisor
  assign fits = (rem_q >= den_q);

  // Load operands, then shift the divisor right one bit per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      den_q <= '0;
      quo_q <= '0;
    end else if (ctrl_i.load) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (ctrl_i.step) begin
      if (fits) begin
        rem_q <= rem_q - den_q;
      end
      den_q <= den_q >> 1;
      quo_q <= {quo_q[lsba_pkg::QuoBits-2:0], fits};
    end
  end

  assign quo_o = quo_q;

endmodule

// ===== design/light_sensor_brightness_average.sv =====
// Light sensor brightness averager: percent per sample, gained, clamped and snapped level per block.
// Sequence: the percent and level dividers take each sample on accept; the sample that closes an
// average adds a second serial division for the block mean, a gain multiply and a clamp step.
// One sample is handled at a time: the next item is taken once the result is registered, and
// that waits while the previous result has not yet been taken by ready.
// Reset: registers return to their defaults, sum 0, count 1, level and reported level 0.
module light_sensor_brightness_average #(
  parameter int unsigned SAMPLES_PER_AVERAGE = 5,
  parameter int unsigned ADC_BITS            = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  lsba_in_if.sink                           in_i,
  lsba_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [lsba_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [lsba_pkg::CfgW-1:0]         cfg_data_i
);

  localparam int unsigned RW     = ADC_BITS + lsba_pkg::QuoBits;
  localparam int unsigned SumW   = $clog2(SAMPLES_PER_AVERAGE * lsba_pkg::LvlSpan + 1);
  localparam int unsigned CntW   = $clog2(SAMPLES_PER_AVERAGE + 1);
  localparam logic [RW-1:0] FullW = {{(RW-ADC_BITS){1'b0}}, {ADC_BITS{1'b1}}};
  localparam logic [RW-1:0] DenAdc = FullW << (lsba_pkg::QuoBits - 1);
  localparam logic [RW-1:0] DenAvg = RW'(SAMPLES_PER_AVERAGE) << (lsba_pkg::QuoBits - 1);
  localparam logic [CntW-1:0] CntTop = CntW'(SAMPLES_PER_AVERAGE);
  localparam logic [lsba_pkg::StepW-1:0] StepLast = lsba_pkg::StepW'(lsba_pkg::QuoBits - 1);

  // Configuration registers
  logic [lsba_pkg::CfgW-1:0] max_q, min_q, upper_q, lower_q, gain_q, thresh_q;

  // Sequencer and block state
  lsba_pkg::state_e                 state_q, state_d;
  logic [lsba_pkg::StepW-1:0]       step_q;
  logic [SumW-1:0]                  sum_q;
  logic [CntW-1:0]                  count_q;
  logic [lsba_pkg::LevelW-1:0]      avg_q;
  logic [lsba_pkg::LevelW-1:0]      rep_q;
  logic [lsba_pkg::PctW-1:0]        pct_q;
  logic [lsba_pkg::ProdW-1:0]       prod_q;

  // Output register
  logic                             out_valid_q;
  logic [lsba_pkg::PctW-1:0]        out_pct_q;
  logic [lsba_pkg::LevelW-1:0]      out_level_q;
  logic                             out_upd_q;

  // Datapath signals
  logic                             accept;
  logic                             out_free;
  logic                             avg_due;
  logic                             out_load;
  logic [RW-1:0]                    sample_w, sat_w;
  logic [RW-1:0]                    num_pct, num_lvl, lvl_num, lvl_den;
  logic [SumW-1:0]                  sum_new;
  logic [lsba_pkg::QuoBits-1:0]     pct_quo, lvl_quo;
  logic [lsba_pkg::GainedW-1:0]     gained, v_lo, v_hi, v_up, v_snap;
  logic [lsba_pkg::LevelW-1:0]      diff;
  logic                             upd;
  lsba_pkg::div_ctrl_t              pct_ctrl, lvl_ctrl;

  // Write configuration registers, ignore indexes past the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= lsba_pkg::MaxLevelRst;
      min_q    <= lsba_pkg::MinLevelRst;
      upper_q  <= lsba_pkg::UpperSnapRst;
      lower_q  <= lsba_pkg::LowerSnapRst;
      gain_q   <= lsba_pkg::GainRst;
      thresh_q <= lsba_pkg::ThreshRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lsba_pkg::CFG_MAX_LEVEL:        max_q    <= cfg_data_i;
        lsba_pkg::CFG_MIN_LEVEL:        min_q    <= cfg_data_i;
        lsba_pkg::CFG_UPPER_SNAP_LIMIT: upper_q  <= cfg_data_i;
        lsba_pkg::CFG_LOWER_SNAP_LIMIT: lower_q  <= cfg_data_i;
        lsba_pkg::CFG_GAIN_Q2_6:        gain_q   <= cfg_data_i;
        lsba_pkg::CFG_CHANGE_THRESHOLD: thresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturate the sample to full scale and form both numerators
  assign sample_w = RW'(in_i.adc_sample);
  assign sat_w    = (sample_w > FullW) ? FullW : sample_w;
  assign num_pct  = sat_w * RW'(lsba_pkg::PctSpan);
  assign num_lvl  = sat_w * RW'(lsba_pkg::LvlSpan);

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign avg_due  = (count_q >= CntTop);
  assign sum_new  = sum_q + SumW'(lvl_quo);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lsba_pkg::ST_IDLE:  if (accept) state_d = lsba_pkg::ST_DIV;
      lsba_pkg::ST_DIV:   if (step_q == StepLast) state_d = lsba_pkg::ST_ACC;
      lsba_pkg::ST_ACC:   state_d = avg_due ? lsba_pkg::ST_MEAN : lsba_pkg::ST_DONE;
      lsba_pkg::ST_MEAN:  if (step_q == StepLast) state_d = lsba_pkg::ST_GAIN;
      lsba_pkg::ST_GAIN:  state_d = lsba_pkg::ST_LEVEL;
      lsba_pkg::ST_LEVEL: state_d = lsba_pkg::ST_DONE;
      lsba_pkg::ST_DONE:  if (out_free) state_d = lsba_pkg::ST_IDLE;
      default:            state_d = lsba_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_i.ready    = (state_q == lsba_pkg::ST_IDLE);
    pct_ctrl.load = (state_q == lsba_pkg::ST_IDLE) && in_i.valid;
    pct_ctrl.step = (state_q == lsba_pkg::ST_DIV);
    lvl_ctrl.load = ((state_q == lsba_pkg::ST_IDLE) && in_i.valid) ||
                    ((state_q == lsba_pkg::ST_ACC) && avg_due);
    lvl_ctrl.step = (state_q == lsba_pkg::ST_DIV) || (state_q == lsba_pkg::ST_MEAN);
    lvl_num       = (state_q == lsba_pkg::ST_IDLE) ? num_lvl : RW'(sum_new);
    lvl_den       = (state_q == lsba_pkg::ST_IDLE) ? DenAdc : DenAvg;
    out_load      = (state_q == lsba_pkg::ST_DONE) && out_free;
  end

  // Percent divider
  lsba_serdiv #(.W(RW)) u_div_pct (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (pct_ctrl),
    .num_i  (num_pct),
    .den_i  (DenAdc),
    .quo_o  (pct_quo)
  );

  // Level divider, reused for the block mean
  lsba_serdiv #(.W(RW)) u_div_lvl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (lvl_ctrl),
    .num_i  (lvl_num),
    .den_i  (lvl_den),
    .quo_o  (lvl_quo)
  );

  // Clamp low then high, then snap upper then lower
  assign gained = prod_q[lsba_pkg::ProdW-1:lsba_pkg::GainFrac];
  always_comb begin
    v_lo   = (gained < lsba_pkg::GainedW'(min_q)) ? lsba_pkg::GainedW'(min_q) : gained;
    v_hi   = (v_lo > lsba_pkg::GainedW'(max_q)) ? lsba_pkg::GainedW'(max_q) : v_lo;
    v_up   = (v_hi >= lsba_pkg::GainedW'(upper_q)) ? lsba_pkg::GainedW'(max_q) : v_hi;
    v_snap = (v_up <= lsba_pkg::GainedW'(lower_q)) ? lsba_pkg::GainedW'(min_q) : v_up;
  end

  // Distance to the last reported level
  assign diff = (avg_q >= rep_q) ? (avg_q - rep_q) : (rep_q - avg_q);
  assign upd  = (diff >= thresh_q);

  // Advance state, step counter and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsba_pkg::ST_IDLE;
      step_q      <= '0;
      sum_q       <= '0;
      count_q     <= CntW'(1);
      avg_q       <= '0;
      rep_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == lsba_pkg::ST_DIV) || (state_q == lsba_pkg::ST_MEAN)) begin
        step_q <= (step_q == StepLast) ? '0 : step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
      if (state_q == lsba_pkg::ST_ACC) begin
        if (avg_due) begin
          sum_q   <= '0;
          count_q <= CntW'(1);
        end else begin
          sum_q   <= sum_new;
          count_q <= count_q + 1'b1;
        end
      end
      if (state_q == lsba_pkg::ST_LEVEL) begin
        avg_q <= v_snap[lsba_pkg::LevelW-1:0];
      end
      if (out_load && upd) begin
        rep_q <= avg_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold percent, gain product and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == lsba_pkg::ST_ACC) begin
      pct_q <= pct_quo[lsba_pkg::PctW-1:0];
    end
    if (state_q == lsba_pkg::ST_GAIN) begin
      prod_q <= lsba_pkg::ProdW'(lvl_quo) * lsba_pkg::ProdW'(gain_q);
    end
    if (out_load) begin
      out_pct_q   <= pct_q;
      out_level_q <= avg_q;
      out_upd_q   <= upd;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.raw_percent   = out_pct_q;
  assign out_o.level         = out_level_q;
  assign out_o.level_updated = out_upd_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the light sensor brightness averager.
module tb_top;

  localparam int unsigned AdcFull       = (1 << lsba_pkg::AdcInW) - 1;
  localparam int unsigned SamplesPerAvg = 5;
  localparam int unsigned RandItems     = 850;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned SettleCycles  = 40;
  // Indexes past the last register; writes to them must change nothing
  localparam logic [lsba_pkg::CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [lsba_pkg::CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

  typedef struct packed {
    logic [lsba_pkg::PctW-1:0]   raw_percent;
    logic [lsba_pkg::LevelW-1:0] level;
    logic                        level_updated;
  } bright_res_t;

  typedef struct packed {
    logic                         is_cfg;
    logic [lsba_pkg::CfgIdxW-1:0] idx;
    logic [lsba_pkg::CfgW-1:0]    data;
    logic [lsba_pkg::AdcInW-1:0]  sample;
    logic                         typed;
    bright_res_t                  want;
  } dir_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [lsba_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [lsba_pkg::CfgW-1:0]    cfg_data_i;

  lsba_in_if  in_ch ();
  lsba_out_if out_ch ();

  light_sensor_brightness_average #(
    .SAMPLES_PER_AVERAGE(SamplesPerAvg),
    .ADC_BITS           (lsba_pkg::AdcInW)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the registers and the averaging state
  logic [lsba_pkg::CfgW-1:0]   sh_max    = lsba_pkg::MaxLevelRst;
  logic [lsba_pkg::CfgW-1:0]   sh_min    = lsba_pkg::MinLevelRst;
  logic [lsba_pkg::CfgW-1:0]   sh_upper  = lsba_pkg::UpperSnapRst;
  logic [lsba_pkg::CfgW-1:0]   sh_lower  = lsba_pkg::LowerSnapRst;
  logic [lsba_pkg::CfgW-1:0]   sh_gain   = lsba_pkg::GainRst;
  logic [lsba_pkg::CfgW-1:0]   sh_thresh = lsba_pkg::ThreshRst;
  logic [10:0]                 acc_sum   = '0;
  logic [2:0]                  acc_count = 3'd1;
  logic [lsba_pkg::LevelW-1:0] avg_level = '0;
  logic [lsba_pkg::LevelW-1:0] rep_level = '0;

  bright_res_t brightness_q [$];

  bit          tx_no_gap   = 1'b0;
  bit          rx_no_stall = 1'b0;
  int unsigned n_errors    = 0;
  int unsigned n_items     = 0;
  int unsigned n_averages  = 0;
  int unsigned n_updates   = 0;
  int unsigned n_cfg_wr    = 0;
  int unsigned n_phases    = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Advance the averager by one sample and return the result it owes
  function automatic bright_res_t predict_brightness(
      input logic [lsba_pkg::AdcInW-1:0] sample);
    int unsigned s;
    int unsigned scaled;
    int unsigned v;
    int unsigned diff;
    bright_res_t r;
    s = sample;
    if (s > AdcFull) s = AdcFull;
    r.raw_percent = lsba_pkg::PctW'(s * lsba_pkg::PctSpan / AdcFull);
    scaled = s * lsba_pkg::LvlSpan / AdcFull;
    acc_sum = acc_sum + 11'(scaled);
    if (acc_count >= SamplesPerAvg) begin
      v = acc_sum;
      v = (v / SamplesPerAvg) * sh_gain;
      v = v >> lsba_pkg::GainFrac;
      // Lower clamp before upper, upper snap before lower
      if (v < sh_min) v = sh_min;
      if (v > sh_max) v = sh_max;
      if (v >= sh_upper) v = sh_max;
      if (v <= sh_lower) v = sh_min;
      avg_level = lsba_pkg::LevelW'(v);
      acc_sum = '0;
      acc_count = 3'd1;
      n_averages++;
    end else begin
      acc_count = acc_count + 3'd1;
    end
    diff = (avg_level >= rep_level) ? avg_level - rep_level : rep_level - avg_level;
    r.level_updated = 1'b0;
    if (diff >= sh_thresh) begin
      r.level_updated = 1'b1;
      rep_level = avg_level;
      n_updates++;
    end
    r.level = avg_level;
    return r;
  endfunction

  function automatic dir_row_t row_cfg(input logic [lsba_pkg::CfgIdxW-1:0] idx,
                                       input logic [lsba_pkg::CfgW-1:0] data);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic dir_row_t row_smp(input logic [lsba_pkg::AdcInW-1:0] sample);
    dir_row_t r;
    r = '0;
    r.sample = sample;
    return r;
  endfunction

  function automatic dir_row_t row_chk(input logic [lsba_pkg::AdcInW-1:0] sample,
                                       input logic [lsba_pkg::PctW-1:0] pct,
                                       input logic [lsba_pkg::LevelW-1:0] level,
                                       input logic upd);
    dir_row_t r;
    r = row_smp(sample);
    r.typed = 1'b1;
    r.want = '{raw_percent: pct, level: level, level_updated: upd};
    return r;
  endfunction

  // Register value with the extremes drawn often
  function automatic logic [lsba_pkg::CfgW-1:0] pick_cfg_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return lsba_pkg::CfgW'($urandom_range(0, 255));
    endcase
  endfunction

  // Write one register; hold the enable high, the caller drops it
  task automatic cfg_write(input logic [lsba_pkg::CfgIdxW-1:0] idx,
                           input logic [lsba_pkg::CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      lsba_pkg::CFG_MAX_LEVEL:        sh_max    = data;
      lsba_pkg::CFG_MIN_LEVEL:        sh_min    = data;
      lsba_pkg::CFG_UPPER_SNAP_LIMIT: sh_upper  = data;
      lsba_pkg::CFG_LOWER_SNAP_LIMIT: sh_lower  = data;
      lsba_pkg::CFG_GAIN_Q2_6:        sh_gain   = data;
      lsba_pkg::CFG_CHANGE_THRESHOLD: sh_thresh = data;
      default: ;
    endcase
    n_cfg_wr++;
  endtask

  // Hold the sender until every pending result has come back
  task automatic wait_drained();
    if (brightness_q.size() != 0) begin
      in_ch.valid <= 1'b0;
      while (brightness_q.size() != 0) @(posedge clk_i);
    end
  endtask

  // Offer one sample, predict on acceptance
  task automatic send_sample(input logic [lsba_pkg::AdcInW-1:0] sample, input logic typed,
                             input bright_res_t want);
    int unsigned gap;
    bright_res_t pred;
    gap = tx_no_gap ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.adc_sample <= sample;
    do @(posedge clk_i); while (!in_ch.ready);
    pred = predict_brightness(sample);
    brightness_q.push_back(typed ? want : pred);
    n_items++;
  endtask

  // Result side: stall at random, check each item against the oldest expectation
  initial begin : result_sink
    int unsigned stall;
    bright_res_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = rx_no_stall ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      if (brightness_q.size() == 0) begin
        $error("result with no pending expectation");
        n_errors++;
      end else begin
        want = brightness_q.pop_front();
        if (out_ch.raw_percent !== want.raw_percent) begin
          $error("raw_percent: expected %0d, got %0d", want.raw_percent, out_ch.raw_percent);
          n_errors++;
        end
        if (out_ch.level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, out_ch.level);
          n_errors++;
        end
        if (out_ch.level_updated !== want.level_updated) begin
          $error("level_updated: expected %0d, got %0d", want.level_updated,
                 out_ch.level_updated);
          n_errors++;
        end
      end
    end
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus: directed table, then random phases
  initial begin : stimulus
    dir_row_t                    dir_tab [$];
    int unsigned                 rand_start;
    int unsigned                 phase_len;
    int unsigned                 base;
    int                          near;
    logic [lsba_pkg::AdcInW-1:0] s;

    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= lsba_pkg::CFG_MAX_LEVEL;
    cfg_data_i       <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.adc_sample <= '0;

    // Level after reset, full scale, first average under default settings
    dir_tab.push_back(row_chk(12'd0, 7'd0, 8'd0, 1'b0));
    dir_tab.push_back(row_chk(12'hFFF, 7'd100, 8'd0, 1'b0));
    dir_tab.push_back(row_smp(12'hFFF));
    dir_tab.push_back(row_smp(12'hFFF));
    dir_tab.push_back(row_chk(12'hFFF, 7'd100, 8'd100, 1'b1));
    // Writes past the register list, then min above max with full gain
    dir_tab.push_back(row_cfg(CfgIdxSpareLo, 8'hFF));
    dir_tab.push_back(row_cfg(CfgIdxSpareHi, 8'h00));
    dir_tab.push_back(row_cfg(lsba_pkg::CFG_MIN_LEVEL, 8'd200));
    dir_tab.push_back(row_cfg(lsba_pkg::CFG_MAX_LEVEL, 8'd50));
    dir_tab.push_back(row_cfg(lsba_pkg::CFG_GAIN_Q2_6, 8'd255));
    dir_tab.push_back(row_smp(12'd1));
    dir_tab.push_back(row_smp(12'd2048));
    dir_tab.push_back(row_smp(12'd4094));
    dir_tab.push_back(row_smp(12'hFFF));
    dir_tab.push_back(row_smp(12'd1));
    // Both snaps apply, zero threshold flags every sample
    dir_tab.push_back(row_cfg(lsba_pkg::CFG_UPPER_SNAP_LIMIT, 8'd10));
    dir_tab.push_back(row_cfg(lsba_pkg::CFG_LOWER_SNAP_LIMIT, 8'd250));
    dir_tab.push_back(row_cfg(lsba_pkg::CFG_CHANGE_THRESHOLD, 8'd0));
    dir_tab.push_back(row_cfg(lsba_pkg::CFG_GAIN_Q2_6, 8'd64));
    dir_tab.push_back(row_cfg(lsba_pkg::CFG_MAX_LEVEL, 8'd255));
    dir_tab.push_back(row_cfg(lsba_pkg::CFG_MIN_LEVEL, 8'd0));
    dir_tab.push_back(row_smp(12'hAAA));
    dir_tab.push_back(row_smp(12'h555));
    dir_tab.push_back(row_smp(12'h800));
    dir_tab.push_back(row_smp(12'h7FF));
    dir_tab.push_back(row_smp(12'hFFF));
    // Zero gain, widest snap window, largest threshold
    dir_tab.push_back(row_cfg(lsba_pkg::CFG_CHANGE_THRESHOLD, 8'd255));
    dir_tab.push_back(row_cfg(lsba_pkg::CFG_GAIN_Q2_6, 8'd0));
    dir_tab.push_back(row_cfg(lsba_pkg::CFG_UPPER_SNAP_LIMIT, 8'd255));
    dir_tab.push_back(row_cfg(lsba_pkg::CFG_LOWER_SNAP_LIMIT, 8'd0));
    repeat (5) dir_tab.push_back(row_smp(12'hFFF));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the table; registers change only with nothing in flight
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        wait_drained();
        cfg_write(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        cfg_we_i <= 1'b0;
        send_sample(dir_tab[i].sample, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    rand_start = n_items;
    while (n_items - rand_start < RandItems) begin
      wait_drained();
      if (n_phases == 0) begin
        // Restore the defaults once
        cfg_write(lsba_pkg::CFG_MAX_LEVEL, lsba_pkg::MaxLevelRst);
        cfg_write(lsba_pkg::CFG_MIN_LEVEL, lsba_pkg::MinLevelRst);
        cfg_write(lsba_pkg::CFG_UPPER_SNAP_LIMIT, lsba_pkg::UpperSnapRst);
        cfg_write(lsba_pkg::CFG_LOWER_SNAP_LIMIT, lsba_pkg::LowerSnapRst);
        cfg_write(lsba_pkg::CFG_GAIN_Q2_6, lsba_pkg::GainRst);
        cfg_write(lsba_pkg::CFG_CHANGE_THRESHOLD, lsba_pkg::ThreshRst);
      end else begin
        for (int r = lsba_pkg::CFG_MAX_LEVEL; r <= lsba_pkg::CFG_CHANGE_THRESHOLD; r++) begin
          if ($urandom_range(0, 1) == 1) cfg_write(lsba_pkg::CfgIdxW'(r), pick_cfg_value());
        end
        if ($urandom_range(0, 5) == 0) begin
          cfg_write($urandom_range(0, 1) ? CfgIdxSpareLo : CfgIdxSpareHi, pick_cfg_value());
        end
      end
      cfg_we_i <= 1'b0;

      tx_no_gap   = ($urandom_range(0, 3) == 0);
      rx_no_stall = ($urandom_range(0, 3) == 0);
      phase_len   = $urandom_range(20, 70);
      base        = $urandom_range(0, AdcFull);

      repeat (phase_len) begin
        // Now and then hold the sender until the block is empty
        if ($urandom_range(0, 39) == 0) wait_drained();
        case ($urandom_range(0, 7))
          0: s = '0;
          1: s = '1;
          2: s = lsba_pkg::AdcInW'(1) << $urandom_range(0, lsba_pkg::AdcInW - 1);
          3, 4, 5: begin
            // Stay near one brightness so averages land around the limits
            near = int'(base) + int'($urandom_range(0, 300)) - 150;
            if (near < 0) near = 0;
            if (near > int'(AdcFull)) near = int'(AdcFull);
            s = lsba_pkg::AdcInW'(near);
          end
          default: s = lsba_pkg::AdcInW'($urandom_range(0, AdcFull));
        endcase
        send_sample(s, 1'b0, '0);
      end
      n_phases++;
    end

    // Drain, then watch a while for stray results
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Run covered %0d samples over %0d random setting phases and %0d register writes.",
             n_items, n_phases, n_cfg_wr);
    $display("The averager formed %0d levels and flagged %0d updates.", n_averages, n_updates);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lsba_pkg.sv
design/lsba_in_if.sv
design/lsba_out_if.sv
design/lsba_serdiv.sv
design/light_sensor_brightness_average.sv
tb/tb_top.sv
